>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every sampled edge outside reset
`define ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// ante in a cycle implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante in a cycle implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mrrpm_pkg.sv
package mrrpm_pkg;

   localparam int FIELD_W     = 12;
   localparam int RING_SIZE_W = 13;
   localparam int ACT_W       = 3;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [RING_SIZE_W-1:0] RING_SIZE_RESET = 13'd4096;
   localparam logic [ACT_W-1:0]       ACT_RESET       = 3'd1;

   // register index, taken from paddr[2]
   localparam logic REG_RING_SIZE      = 1'b0;
   localparam logic REG_ACTIVE_READERS = 1'b1;

   localparam logic [1:0] MODE_WRITER = 2'd0;
   localparam logic [1:0] MODE_READER = 2'd1;
   localparam logic [1:0] MODE_EOS    = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [1:0]         reader_index;
      logic [FIELD_W-1:0] length;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] amount;
      logic [FIELD_W-1:0] first_start;
      logic [FIELD_W-1:0] first_length;
      logic [FIELD_W-1:0] second_length;
      logic               stream_ended;
      logic               rejected;
   } rsp_type;

endpackage

>>> rtl/mrrpm_csr.sv
module mrrpm_csr import mrrpm_pkg::*; #(
   parameter int MAX_READERS    = 4,
   parameter int RING_SLOTS_MAX = 4096,
   localparam int SW  = $clog2(RING_SLOTS_MAX + 1),
   localparam int RCW = $clog2(MAX_READERS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output logic [SW-1:0]     slots,
   output logic [RCW-1:0]    readers,
   output logic              ring_clear
);

   logic [RING_SIZE_W-1:0] ring_size_ff, ring_size_in;
   logic [ACT_W-1:0]       act_ff, act_in;
   logic [SW-1:0]          slots_ff, slots_in;
   logic [RCW-1:0]         readers_ff, readers_in;
   logic                   wr;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;

   always_comb begin
      int rs;
      int ar;
      rs           = int'(pwdata[RING_SIZE_W-1:0]);
      ar           = int'(pwdata[ACT_W-1:0]);
      ring_size_in = ring_size_ff;
      act_in       = act_ff;
      slots_in     = slots_ff;
      readers_in   = readers_ff;
      if (wr && paddr[2] == REG_RING_SIZE) begin
         ring_size_in = pwdata[RING_SIZE_W-1:0];
         slots_in     = SW'((rs < 2) ? 2 : ((rs > RING_SLOTS_MAX) ? RING_SLOTS_MAX : rs));
      end
      if (wr && paddr[2] == REG_ACTIVE_READERS) begin
         act_in     = pwdata[ACT_W-1:0];
         readers_in = RCW'((ar > MAX_READERS) ? MAX_READERS : ar);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= RING_SIZE_RESET;
         act_ff       <= ACT_RESET;
         slots_ff     <= SW'((RING_SLOTS_MAX < 4096) ? RING_SLOTS_MAX : 4096);
         readers_ff   <= RCW'(1);
      end else begin
         ring_size_ff <= ring_size_in;
         act_ff       <= act_in;
         slots_ff     <= slots_in;
         readers_ff   <= readers_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_RING_SIZE:      prdata = DATA_W'(ring_size_ff);
         REG_ACTIVE_READERS: prdata = DATA_W'(act_ff);
         default:            prdata = '0;
      endcase
   end

   assign slots      = slots_ff;
   assign readers    = readers_ff;
   assign ring_clear = wr && paddr[2] == REG_RING_SIZE;

endmodule

>>> rtl/mrrpm_space.sv
module mrrpm_space import mrrpm_pkg::*; #(
   parameter int MAX_READERS    = 4,
   parameter int RING_SLOTS_MAX = 4096,
   localparam int PW  = $clog2(RING_SLOTS_MAX),
   localparam int SW  = $clog2(RING_SLOTS_MAX + 1),
   localparam int RCW = $clog2(MAX_READERS + 1)
) (
   input  logic [PW-1:0]                  write_pos,
   input  logic [MAX_READERS-1:0][PW-1:0] read_pos,
   input  logic [SW-1:0]                  slots,
   input  logic [RCW-1:0]                 readers,
   output logic [PW-1:0]                  space
);

   localparam int P = 1 << $clog2(MAX_READERS);

   // min tree: leaves at P-1 .. 2P-2, node k combines 2k+1 and 2k+2
   logic [SW-1:0] node_d [2*P-1];
   logic          node_v [2*P-1];

   genvar i, k;
   generate
      for (i = 0; i < P; i++) begin : g_leaf
         if (i < MAX_READERS) begin : g_real
            logic [SW:0] diff;
            logic [SW:0] wrapped;
            assign diff    = (SW+1)'(read_pos[i]) - (SW+1)'(write_pos);
            assign wrapped = diff + (SW+1)'(slots);
            // equal positions count as a full ring
            assign node_d[P-1+i] = diff[SW] ? wrapped[SW-1:0] :
                                   ((diff == '0) ? slots : diff[SW-1:0]);
            assign node_v[P-1+i] = RCW'(i) < readers;
         end else begin : g_pad
            assign node_d[P-1+i] = '0;
            assign node_v[P-1+i] = 1'b0;
         end
      end
      for (k = 0; k < P-1; k++) begin : g_node
         logic pick_r;
         assign pick_r = !node_v[2*k+1] ||
                         (node_v[2*k+2] && node_d[2*k+2] < node_d[2*k+1]);
         assign node_d[k] = pick_r ? node_d[2*k+2] : node_d[2*k+1];
         assign node_v[k] = node_v[2*k+1] | node_v[2*k+2];
      end
   endgenerate

   assign space = node_v[0] ? PW'(node_d[0] - SW'(1)) : '0;

endmodule

>>> rtl/multi_reader_ring_pointer_manager.sv
// A transaction is taken into the input register and its result into the result register.
// Throughput: one transaction per cycle; busy stays low, the path from the input register
// through the reader minimum tree and pointer update to the result register is combinational.
// Results cannot be stalled; each is on rsp_item for exactly one cycle with rsp_valid.
// Synchronous reset: ring_size 4096, active_readers 1, all positions 0, end mark clear.
`include "assert_macros.svh"

module multi_reader_ring_pointer_manager import mrrpm_pkg::*; #(
   parameter int MAX_READERS    = 4,
   parameter int RING_SLOTS_MAX = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_item,
   output logic              rsp_valid,
   output rsp_type           rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int PW  = $clog2(RING_SLOTS_MAX);
   localparam int SW  = $clog2(RING_SLOTS_MAX + 1);
   localparam int RCW = $clog2(MAX_READERS + 1);
   localparam int AW  = ((PW > FIELD_W) ? PW : FIELD_W) + 1;
   localparam int IW  = (RCW > 2) ? RCW : 2;

   logic [SW-1:0]  slots;
   logic [RCW-1:0] readers;
   logic           ring_clear;

   logic                           in_valid_ff;
   req_type                        in_ff;
   logic [PW-1:0]                  wp_ff, wp_in;
   logic [MAX_READERS-1:0][PW-1:0] rd_pos_ff, rd_pos_in;
   logic                           eos_ff, eos_in;
   logic                           rsp_valid_ff;
   rsp_type                        rsp_ff, rsp_in;

   logic [PW-1:0] space;
   logic [PW-1:0] sel_rp;
   logic          r_active;
   logic [SW:0]   av_diff, av_wrap;
   logic [PW-1:0] avail;
   logic [PW-1:0] amt_pre, pos_pre, amt_post, pos_post;
   logic          rej;
   logic [AW-1:0] pos_sum;
   logic [SW-1:0] tail, amt_ext, first_len;

   mrrpm_csr #(
      .MAX_READERS    (MAX_READERS),
      .RING_SLOTS_MAX (RING_SLOTS_MAX)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .slots      (slots),
      .readers    (readers),
      .ring_clear (ring_clear)
   );

   mrrpm_space #(
      .MAX_READERS    (MAX_READERS),
      .RING_SLOTS_MAX (RING_SLOTS_MAX)
   ) u_space (
      .write_pos (wp_ff),
      .read_pos  (rd_pos_ff),
      .slots     (slots),
      .readers   (readers),
      .space     (space)
   );

   assign busy = 1'b0;

   always_comb begin
      sel_rp = '0;
      for (int i = 0; i < MAX_READERS; i++) begin
         if (i == int'(in_ff.reader_index)) sel_rp = rd_pos_ff[i];
      end
   end

   assign r_active = IW'(in_ff.reader_index) < IW'(readers);
   assign av_diff  = (SW+1)'(wp_ff) - (SW+1)'(sel_rp);
   assign av_wrap  = av_diff + (SW+1)'(slots);
   assign avail    = av_diff[SW] ? PW'(av_wrap) : PW'(av_diff);

   assign amt_pre  = (in_ff.mode == MODE_WRITER) ? space : avail;
   assign pos_pre  = (in_ff.mode == MODE_WRITER) ? wp_ff : sel_rp;
   assign rej      = AW'(in_ff.length) > AW'(amt_pre);
   assign pos_sum  = AW'(pos_pre) + AW'(in_ff.length);
   assign pos_post = rej ? pos_pre :
                     ((pos_sum >= AW'(slots)) ? PW'(pos_sum - AW'(slots)) : PW'(pos_sum));
   assign amt_post = rej ? amt_pre : PW'(AW'(amt_pre) - AW'(in_ff.length));

   // split at the wrap point
   assign tail      = slots - SW'(pos_post);
   assign amt_ext   = SW'(amt_post);
   assign first_len = (amt_ext <= tail) ? amt_ext : tail;

   always_comb begin
      wp_in     = wp_ff;
      rd_pos_in = rd_pos_ff;
      eos_in    = eos_ff;
      rsp_in    = '0;
      if (in_valid_ff) begin
         case (in_ff.mode)
            MODE_WRITER: begin
               wp_in                = pos_post;
               rsp_in.amount        = FIELD_W'(amt_post);
               rsp_in.first_start   = FIELD_W'(pos_post);
               rsp_in.first_length  = FIELD_W'(first_len);
               rsp_in.second_length = FIELD_W'(amt_ext - first_len);
               rsp_in.rejected      = rej;
            end
            MODE_READER: begin
               if (r_active) begin
                  for (int i = 0; i < MAX_READERS; i++) begin
                     if (i == int'(in_ff.reader_index)) rd_pos_in[i] = pos_post;
                  end
                  rsp_in.amount        = FIELD_W'(amt_post);
                  rsp_in.first_start   = FIELD_W'(pos_post);
                  rsp_in.first_length  = FIELD_W'(first_len);
                  rsp_in.second_length = FIELD_W'(amt_ext - first_len);
                  rsp_in.rejected      = rej;
               end else begin
                  rsp_in.rejected = in_ff.length != '0;
               end
            end
            MODE_EOS: begin
               eos_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
      rsp_in.stream_ended = eos_in;
      // new ring size empties the ring; the user must write it only while idle, the block does not enforce this
      if (ring_clear) begin
         wp_in     = '0;
         rd_pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         wp_ff        <= '0;
         rd_pos_ff    <= '0;
         eos_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start & ~busy;
         wp_ff        <= wp_in;
         rd_pos_ff    <= rd_pos_in;
         eos_ff       <= eos_in;
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start & ~busy) in_ff <= req_item;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ASSERT_NEXT(a_one_result, clock, reset, in_valid_ff, rsp_valid_ff, "transaction produced no result")
   `ASSERT_NEXT(a_rej_hold, clock, reset, in_valid_ff && rsp_in.rejected, $stable(wp_ff) && $stable(rd_pos_ff), "rejected commit moved a position")
   `ASSERT_IMPL(a_seg_sum, clock, reset, rsp_valid_ff, FIELD_W'(rsp_ff.first_length + rsp_ff.second_length) == rsp_ff.amount, "segments do not add up to amount")

endmodule
